### hdl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the life grid generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Grid geometry: row and column indexes are IDX_W bits wide
    localparam int IDX_W    = 5;
    localparam int GRID_MAX = 1 << IDX_W;
    localparam int SIZE_W   = 6;
    localparam int CNT_W    = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(20);

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // One row of cells, bit c is column c
    typedef logic [GRID_MAX-1:0] t_row;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch the accepted word
        logic cell_wr;   // write one cell
        logic cell_rd;   // read the row of one cell
        logic rd_up;     // read last active row (up neighbor of row 0)
        logic rd_row0;   // read row 0
        logic row_rd;    // read row below the current one
        logic cap_prev;  // capture read data as previous row
        logic cap_cur;   // capture read data as current row and row 0 copy
        logic row_wr;    // write back computed row, shift row window
        logic finish;    // present a result word
        logic use_rd;    // result carries read data
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last_row;  // row counter sits on last active row
    } t_stat;

endpackage

### hdl/lgs_ctrl.sv
// ----------------------------------------------------------------------------
// lgs_ctrl
// Operation sequencer: decodes accepted words and steps the datapath through
// cell writes, cell reads and the row-by-row generation sweep.
// ----------------------------------------------------------------------------
module lgs_ctrl import lgs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_operation,
    input  t_stat      i_stat,
    output logic       o_busy,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_WRITE     = 4'd1;
    localparam logic [3:0] S_NOP       = 4'd2;
    localparam logic [3:0] S_READ      = 4'd3;
    localparam logic [3:0] S_READ_WAIT = 4'd4;
    localparam logic [3:0] S_LD_UP     = 4'd5;
    localparam logic [3:0] S_LD_CUR    = 4'd6;
    localparam logic [3:0] S_LD_WAIT   = 4'd7;
    localparam logic [3:0] S_ROW_RD    = 4'd8;
    localparam logic [3:0] S_ROW_WR    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_operation)
                        OP_WRITE: n_state = S_WRITE;
                        OP_STEP:  n_state = S_LD_UP;
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_NOP;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.cell_wr = 1'b1;
                o_cmd.finish  = 1'b1;
                n_state       = S_IDLE;
            end
            S_NOP: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                o_cmd.cell_rd = 1'b1;
                n_state       = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                o_cmd.finish = 1'b1;
                o_cmd.use_rd = 1'b1;
                n_state      = S_IDLE;
            end
            // Prime the row window: last row as up neighbor, then row 0
            S_LD_UP: begin
                o_cmd.rd_up = 1'b1;
                n_state     = S_LD_CUR;
            end
            S_LD_CUR: begin
                o_cmd.rd_row0  = 1'b1;
                o_cmd.cap_prev = 1'b1;
                n_state        = S_LD_WAIT;
            end
            S_LD_WAIT: begin
                o_cmd.cap_cur = 1'b1;
                n_state       = S_ROW_RD;
            end
            // Per row: fetch the row below (wrap uses the saved row 0), then write
            S_ROW_RD: begin
                o_cmd.row_rd = !i_stat.last_row;
                n_state      = S_ROW_WR;
            end
            S_ROW_WR: begin
                o_cmd.row_wr = 1'b1;
                if (i_stat.last_row) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_ROW_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // Accepted word always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not make the block busy");

    // A result ends the operation
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE))
        else $error("result issued but sequencer did not return to idle");

    // Single read port: at most one address source per cycle
    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.cell_rd, o_cmd.rd_up, o_cmd.rd_row0, o_cmd.row_rd}))
        else $error("more than one grid read requested");

endmodule

### hdl/lgs_datapath.sv
// ----------------------------------------------------------------------------
// lgs_datapath
// Grid row memory with per-row valid bits, grid size register, three-row
// window and the 32-lane neighbor count / rule logic for one row per write.
// ----------------------------------------------------------------------------
module lgs_datapath import lgs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    input  logic [1:0]        i_operation,
    input  logic [IDX_W-1:0]  i_row,
    input  logic [IDX_W-1:0]  i_column,
    input  logic              i_cell_value,
    output logic              o_done,
    output logic              o_read_value,
    output logic [1:0]        o_completed_operation
);

    localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);
    localparam logic [CNT_W-1:0] KEEP_COUNT  = CNT_W'(2);

    logic [SIZE_W-1:0] r_grid_size;
    logic [SIZE_W-1:0] size_eff;
    logic [IDX_W-1:0]  nm1;

    logic [1:0]       r_op;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic             r_val;

    t_row r_mem [GRID_MAX];
    t_row r_valid;
    t_row r_rdata;
    logic r_rvld;
    t_row rdata_eff;

    t_row r_prev;
    t_row r_cur;
    t_row r_row0;
    t_row dn_row;
    t_row new_row;
    logic [IDX_W-1:0] r_idx;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_row             wr_mask;
    t_row             wr_data;

    logic             r_done;
    logic             r_rd_val;
    logic [1:0]       r_op_out;

    // Grid size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_grid_size <= i_cfg_wr_data;
        end
    end

    // Clamp size to 1..GRID_MAX
    always_comb begin
        if (r_grid_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (r_grid_size > SIZE_W'(GRID_MAX)) begin
            size_eff = SIZE_W'(GRID_MAX);
        end else begin
            size_eff = r_grid_size;
        end
        nm1 = IDX_W'(size_eff - SIZE_W'(1));
    end

    // Accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_row <= i_row;
            r_col <= i_column;
            r_val <= i_cell_value;
        end
    end

    // Row counter for the generation sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.row_wr && !o_stat.last_row) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign o_stat.last_row = (r_idx == nm1);

    // Read address select
    always_comb begin
        rd_en = i_cmd.cell_rd | i_cmd.rd_up | i_cmd.rd_row0 | i_cmd.row_rd;
        if (i_cmd.cell_rd) begin
            rd_addr = r_row;
        end else if (i_cmd.rd_up) begin
            rd_addr = nm1;
        end else if (i_cmd.rd_row0) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_idx + IDX_W'(1);
        end
    end

    // Unwritten rows read as dead
    assign rdata_eff = r_rvld ? r_rdata : '0;
    assign dn_row    = o_stat.last_row ? r_row0 : rdata_eff;

    // Next row: neighbor count per column, torus wrap at the active size
    always_comb begin
        logic [CNT_W-1:0] cnt;
        logic ul, ur, ml, mr, dl, dr;
        new_row = r_cur;
        for (int c = 0; c < GRID_MAX; c++) begin
            if (c == 0) begin
                ul = r_prev[nm1];
                ml = r_cur[nm1];
                dl = dn_row[nm1];
            end else begin
                ul = r_prev[c-1];
                ml = r_cur[c-1];
                dl = dn_row[c-1];
            end
            if (c == GRID_MAX-1 || IDX_W'(c) == nm1) begin
                ur = r_prev[0];
                mr = r_cur[0];
                dr = dn_row[0];
            end else begin
                ur = r_prev[c+1];
                mr = r_cur[c+1];
                dr = dn_row[c+1];
            end
            cnt = CNT_W'(ul) + CNT_W'(r_prev[c]) + CNT_W'(ur)
                + CNT_W'(ml) + CNT_W'(mr)
                + CNT_W'(dl) + CNT_W'(dn_row[c]) + CNT_W'(dr);
            if (IDX_W'(c) <= nm1) begin
                new_row[c] = (cnt == BIRTH_COUNT) | ((cnt == KEEP_COUNT) & r_cur[c]);
            end
        end
    end

    // Write port: whole row on the sweep, one cell (full row if unwritten) otherwise
    always_comb begin
        wr_en = i_cmd.cell_wr | i_cmd.row_wr;
        if (i_cmd.row_wr) begin
            wr_addr = r_idx;
            wr_mask = '1;
            wr_data = new_row;
        end else begin
            wr_addr = r_row;
            wr_mask = r_valid[r_row] ? (t_row'(1) << r_col) : '1;
            wr_data = t_row'(r_val) << r_col;
        end
    end

    // Grid memory, bit-enable write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int i = 0; i < GRID_MAX; i++) begin
                if (wr_mask[i]) begin
                    r_mem[wr_addr][i] <= wr_data[i];
                end
            end
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rvld  <= r_valid[rd_addr];
        end
    end

    // Row valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Row window
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_prev) begin
            r_prev <= rdata_eff;
        end
        if (i_cmd.cap_cur) begin
            r_cur  <= rdata_eff;
            r_row0 <= rdata_eff;
        end
        if (i_cmd.row_wr) begin
            r_prev <= r_cur;
            r_cur  <= dn_row;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_op_out <= r_op;
            r_rd_val <= i_cmd.use_rd ? rdata_eff[r_col] : 1'b0;
        end
    end

    assign o_done                = r_done;
    assign o_read_value          = r_rd_val;
    assign o_completed_operation = r_op_out;

    // Sweep never writes beyond the active rows
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.row_wr |-> (r_idx <= nm1))
        else $error("row write outside active grid");

endmodule

### hdl/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Game of Life (B3/S23) grid on a torus with cell write, cell read and an
// in-place next-generation step.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (operation, row, column, cell_value) is taken at
//   a clock edge with i_start high and o_busy low.
//   Result channel: o_done is high for one cycle with o_read_value and
//   o_completed_operation; the receiver must take it, there is no stall.
//   Config: i_cfg_wr_en writes grid_size; write only while idle.
// Sequence (accepted word to o_done):
//   write and unused code issue the result from their own state; read adds a
//   wait state for the registered grid read; step first primes the row window
//   (read last row, read row 0, capture row 0), then sweeps each active row
//   with a fetch state for the row below and a write-back state for the
//   computed row. In all cases the result register drives o_done. A new word
//   can be taken in the cycle o_done is high.
// Reset: grid_size returns to 20 and all rows read as dead through per-row
//   valid bits, so the block is ready right after reset with no clearing
//   pass.
// ----------------------------------------------------------------------------
module life_grid_generation_step import lgs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_operation,
    input  logic [IDX_W-1:0]  i_row,
    input  logic [IDX_W-1:0]  i_column,
    input  logic              i_cell_value,
    output logic              o_done,
    output logic              o_read_value,
    output logic [1:0]        o_completed_operation,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    lgs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_busy      (o_busy),
        .o_cmd       (cmd)
    );

    // Grid storage and rule logic
    lgs_datapath u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_wr_data         (i_cfg_wr_data),
        .i_operation           (i_operation),
        .i_row                 (i_row),
        .i_column              (i_column),
        .i_cell_value          (i_cell_value),
        .o_done                (o_done),
        .o_read_value          (o_read_value),
        .o_completed_operation (o_completed_operation)
    );

endmodule

### tb/life_grid_generation_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_grid_generation_step_tb
// Self-checking bench for the Game of Life grid. A scoreboard keeps its own
// copy of the grid and grid size, predicts each result word from every
// accepted command word and compares it with what the block returns.
// Directed words cover the grid corners, wrap-around, the unused code and
// out-of-range sizes. Random phases then seed the grid and mix steps,
// reads and writes at several grid sizes.
// ----------------------------------------------------------------------------
module life_grid_generation_step_tb import lgs_pkg::*; ();

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 1000;
    localparam int         TAIL_CYCLES = 80;
    localparam int         NUM_PHASES  = 10;

    // Grid model and queue of expected result words
    class life_scoreboard;
        typedef struct {
            logic       read_value;
            logic [1:0] operation;
        } t_life_result;

        bit [GRID_MAX-1:0]  cells [GRID_MAX];
        logic [SIZE_W-1:0]  grid_size;
        t_life_result       expected_results [$];
        int                 mismatches;

        function new();
            foreach (cells[r]) cells[r] = '0;
            grid_size  = SIZE_RESET;
            mismatches = 0;
        endfunction

        function int active_size();
            if (grid_size == 0) return 1;
            if (grid_size > GRID_MAX) return GRID_MAX;
            return int'(grid_size);
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            grid_size = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // B3/S23 on the active torus; cells outside it are left alone
        function void next_generation();
            bit [GRID_MAX-1:0] nxt [GRID_MAX];
            int n;
            int rr;
            int cc;
            int live;
            n = active_size();
            nxt = cells;
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                    live = 0;
                    // tiny grids count a wrapped position once per offset
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0) begin
                                rr = (r + n + dr) % n;
                                cc = (c + n + dc) % n;
                                live += int'(cells[rr][cc]);
                            end
                        end
                    end
                    if (live == 3) nxt[r][c] = 1'b1;
                    else if (live != 2) nxt[r][c] = 1'b0;
                end
            end
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    cells[r][c] = nxt[r][c];
        endfunction

        // Accepted command word: update the grid, queue its result word
        function void note_word(logic [1:0] op, logic [IDX_W-1:0] row,
                                logic [IDX_W-1:0] col, logic value);
            t_life_result res;
            res.operation  = op;
            res.read_value = 1'b0;
            case (op)
                OP_WRITE: cells[row][col] = value;
                OP_STEP:  next_generation();
                OP_READ:  res.read_value = cells[row][col];
                default:  ;
            endcase
            expected_results.push_back(res);
        endfunction

        // Result word from the block against the oldest expectation
        function void check_result(logic read_value, logic [1:0] op);
            t_life_result res;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: read_value %0b operation %0d",
                             read_value, op);
                return;
            end
            res = expected_results.pop_front();
            if (read_value !== res.read_value || op !== res.operation) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: read_value exp %0b got %0b, %s %0d got %0d",
                             res.read_value, read_value, "operation exp",
                             res.operation, op);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    logic [1:0]        i_operation = OP_WRITE;
    logic [IDX_W-1:0]  i_row = '0;
    logic [IDX_W-1:0]  i_column = '0;
    logic              i_cell_value = 1'b0;
    logic              o_done;
    logic              o_read_value;
    logic [1:0]        o_completed_operation;
    logic              i_cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wr_data = '0;

    life_scoreboard sb;
    int             idle_cycles = 0;
    int             gap_pct = 25;

    life_grid_generation_step u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_start               (i_start),
        .o_busy                (o_busy),
        .i_operation           (i_operation),
        .i_row                 (i_row),
        .i_column              (i_column),
        .i_cell_value          (i_cell_value),
        .o_done                (o_done),
        .o_read_value          (o_read_value),
        .o_completed_operation (o_completed_operation),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_wr_data         (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor: results first (they belong to older words), then commands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result(o_read_value, o_completed_operation);
            if (i_start && !o_busy)
                sb.note_word(i_operation, i_row, i_column, i_cell_value);
            // watchdog on cycles with no word moving either way
            if (o_done || (i_start && !o_busy)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // Hold a command word until the block takes it
    task automatic send_word(logic [1:0] op, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic value);
        i_start      <= 1'b1;
        i_operation  <= op;
        i_row        <= row;
        i_column     <= col;
        i_cell_value <= value;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Optional sender gap, then the word
    task automatic issue(logic [1:0] op, logic [IDX_W-1:0] row,
                         logic [IDX_W-1:0] col, logic value);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        send_word(op, row, col, value);
    endtask

    // Stop sending until every expected result word has come back
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic write_grid_size(logic [SIZE_W-1:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sb.set_size(value);
        i_cfg_wr_en <= 1'b0;
    endtask

    // One random word; mostly within the active grid of size n
    task automatic random_word(int n);
        int               pick;
        logic [1:0]       op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             value;
        pick  = $urandom_range(0, 99);
        row   = IDX_W'($urandom_range(0, n - 1));
        col   = IDX_W'($urandom_range(0, n - 1));
        value = ($urandom_range(0, 99) < 40);
        if (pick < 45) begin
            op = OP_WRITE;
        end else if (pick < 50) begin
            op    = OP_WRITE;
            row   = IDX_W'($urandom_range(0, GRID_MAX - 1));
            col   = IDX_W'($urandom_range(0, GRID_MAX - 1));
            value = 1'($urandom_range(0, 1));
        end else if (pick < 75) begin
            op = OP_READ;
        end else if (pick < 80) begin
            op  = OP_READ;
            row = IDX_W'($urandom_range(0, GRID_MAX - 1));
            col = IDX_W'($urandom_range(0, GRID_MAX - 1));
        end else if (pick < 95) begin
            op = OP_STEP;
        end else begin
            op    = OP_UNUSED;
            row   = IDX_W'($urandom_range(0, GRID_MAX - 1));
            col   = IDX_W'($urandom_range(0, GRID_MAX - 1));
            value = 1'($urandom_range(0, 1));
        end
        if (gap_pct > 0 && $urandom_range(0, 49) == 0) drain();
        issue(op, row, col, value);
    endtask

    initial begin
        int phase_sizes [NUM_PHASES] = '{3, 1, 0, 2, 32, 63, 5, 8, 17, 4};
        int n;
        int seeds;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size: dead grid, corners, block across the wrap corner
        issue(OP_READ,  5'd0,  5'd0,  1'b0);
        issue(OP_READ,  5'd31, 5'd31, 1'b0);
        issue(OP_WRITE, 5'd0,  5'd0,  1'b1);
        issue(OP_WRITE, 5'd31, 5'd31, 1'b1);
        issue(OP_WRITE, 5'd19, 5'd19, 1'b1);
        issue(OP_WRITE, 5'd0,  5'd19, 1'b1);
        issue(OP_WRITE, 5'd19, 5'd0,  1'b1);
        issue(OP_STEP,  5'd0,  5'd0,  1'b0);
        issue(OP_READ,  5'd19, 5'd19, 1'b0);
        issue(OP_READ,  5'd31, 5'd31, 1'b0);
        issue(OP_UNUSED, 5'd31, 5'd31, 1'b1);
        issue(OP_WRITE, 5'd0,  5'd0,  1'b0);
        issue(OP_STEP,  5'd31, 5'd31, 1'b1);
        issue(OP_READ,  5'd0,  5'd19, 1'b0);

        // Size zero acts as one: a lone cell sees itself eight times
        write_grid_size(SIZE_W'(0));
        issue(OP_WRITE, 5'd0, 5'd0, 1'b1);
        issue(OP_STEP,  5'd0, 5'd0, 1'b0);
        issue(OP_READ,  5'd0, 5'd0, 1'b0);

        // Two by two torus
        write_grid_size(SIZE_W'(2));
        issue(OP_WRITE, 5'd0, 5'd1, 1'b1);
        issue(OP_STEP,  5'd0, 5'd0, 1'b0);
        issue(OP_READ,  5'd1, 5'd1, 1'b0);

        // Oversized setting acts as the full store
        write_grid_size(SIZE_W'(63));
        issue(OP_WRITE, 5'd31, 5'd0, 1'b1);
        issue(OP_STEP,  5'd0,  5'd0, 1'b0);
        issue(OP_READ,  5'd31, 5'd0, 1'b0);

        // Random phases: seed the active grid, then mixed traffic
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            gap_pct = (ph == NUM_PHASES - 1) ? 0 : $urandom_range(0, 2) * 25;
            write_grid_size(SIZE_W'(phase_sizes[ph]));
            n     = sb.active_size();
            seeds = (n * n < 24) ? n * n : 24;
            for (int k = 0; k < seeds; k++)
                issue(OP_WRITE, IDX_W'($urandom_range(0, n - 1)),
                      IDX_W'($urandom_range(0, n - 1)),
                      $urandom_range(0, 99) < 40);
            for (int k = 0; k < 40; k++)
                random_word(n);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() > 0)
            $display("%0d expected result words never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
